// ===== rtl/core/twsu_pkg.sv =====
// Shared types and constants of the timing wheel scheduler.
// Used by the front, the command queue, the back and the top level.
package twsu_pkg;

  localparam int TIMEOUT_W   = 16;
  localparam int ID_W        = 8;
  localparam int SLOT_MAX_W  = 8;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    CMD_ADD,
    CMD_ZERO,
    CMD_TICK
  } cmd_op_t;

  typedef enum logic [1:0] {
    KIND_ADDED   = 2'd0,
    KIND_FULL    = 2'd1,
    KIND_ZERO    = 2'd2,
    KIND_EXPIRED = 2'd3
  } kind_t;

  typedef struct packed {
    cmd_op_t                op;
    logic [SLOT_MAX_W-1:0]  slot;
    logic [TIMEOUT_W-1:0]   rounds;
    logic [ID_W-1:0]        id;
  } twsu_cmd_t;

endpackage

// ===== rtl/core/twsu_front.sv =====
// Front end: takes items, tracks the wheel position, classifies adds and ticks.
// Splits timeout-1 into rounds and slot by reciprocal multiply. Uses twsu_pkg.
module twsu_front #(
  parameter int WHEEL_SLOTS = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic                       in_mode,
  input  logic [15:0]                in_timeout,
  input  logic [7:0]                 in_timer_id,
  input  logic                       q_full,
  output logic                       push,
  output twsu_pkg::twsu_cmd_t        push_cmd
);
  import twsu_pkg::*;

  localparam int SLOT_W   = $clog2(WHEEL_SLOTS);
  localparam int SHIFT    = TIMEOUT_W + SLOT_W;
  localparam int RECIP_W  = 18;
  localparam int PROD_W   = TIMEOUT_W + RECIP_W;
  localparam int RECIP_I  = ((2 ** SHIFT) + WHEEL_SLOTS - 1) / WHEEL_SLOTS;
  localparam logic [RECIP_W-1:0]  RECIP    = RECIP_W'(RECIP_I);
  localparam logic [SLOT_W-1:0]   LAST_SL  = SLOT_W'(WHEEL_SLOTS - 1);
  localparam logic [SLOT_W:0]     SLOTS_X  = (SLOT_W + 1)'(WHEEL_SLOTS);

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_DIV,
    F_PUSH
  } fstate_t;

  fstate_t               state_r, state_nxt;
  logic [SLOT_W-1:0]     cur_r, cur_nxt;
  logic [TIMEOUT_W-1:0]  t1_r, t1_nxt;
  logic [PROD_W-1:0]     prod_r, prod_nxt;
  twsu_cmd_t             cmd_r, cmd_nxt;

  logic [TIMEOUT_W-1:0]  quo;
  logic [TIMEOUT_W-1:0]  quo_s;
  logic [TIMEOUT_W-1:0]  rem;
  logic [SLOT_W:0]       sum;
  logic [SLOT_W-1:0]     cur_inc;
  logic                  accept;

  assign busy     = (state_r != F_IDLE);
  assign accept   = start && !busy;
  assign push     = (state_r == F_PUSH) && !q_full;
  assign push_cmd = cmd_r;

  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    t1_nxt    = t1_r;
    prod_nxt  = prod_r;
    cmd_nxt   = cmd_r;
    cur_inc   = (cur_r == LAST_SL) ? '0 : cur_r + SLOT_W'(1);
    quo       = TIMEOUT_W'(prod_r >> SHIFT);
    quo_s     = TIMEOUT_W'(32'(quo) * 32'(WHEEL_SLOTS));
    rem       = t1_r - quo_s;
    sum       = {1'b0, cur_r} + (SLOT_W + 1)'(rem[SLOT_W-1:0]) + (SLOT_W + 1)'(1);
    if (sum >= SLOTS_X) begin
      sum = sum - SLOTS_X;
    end
    unique case (state_r)
      F_IDLE: begin
        if (accept) begin
          cmd_nxt.id     = in_timer_id;
          cmd_nxt.rounds = '0;
          cmd_nxt.slot   = '0;
          if (in_mode) begin
            cur_nxt      = cur_inc;
            cmd_nxt.op   = CMD_TICK;
            cmd_nxt.slot = SLOT_MAX_W'(cur_inc);
            state_nxt    = F_PUSH;
          end else if (in_timeout == '0) begin
            cmd_nxt.op = CMD_ZERO;
            state_nxt  = F_PUSH;
          end else begin
            cmd_nxt.op = CMD_ADD;
            t1_nxt     = in_timeout - TIMEOUT_W'(1);
            state_nxt  = F_MUL;
          end
        end
      end
      F_MUL: begin
        prod_nxt  = PROD_W'(t1_r) * PROD_W'(RECIP);
        state_nxt = F_DIV;
      end
      F_DIV: begin
        cmd_nxt.rounds = quo;
        cmd_nxt.slot   = SLOT_MAX_W'(sum[SLOT_W-1:0]);
        state_nxt      = F_PUSH;
      end
      F_PUSH: begin
        if (!q_full) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      cur_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cur_r   <= cur_nxt;
    end
    t1_r   <= t1_nxt;
    prod_r <= prod_nxt;
    cmd_r  <= cmd_nxt;
  end

endmodule

// ===== rtl/core/twsu_queue.sv =====
// Two-entry command queue between front and back.
// Holds twsu_pkg::twsu_cmd_t items in arrival order.
module twsu_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  twsu_pkg::twsu_cmd_t  push_cmd,
  output logic                 full,
  input  logic                 pop,
  output logic                 not_empty,
  output twsu_pkg::twsu_cmd_t  pop_cmd
);
  import twsu_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  twsu_cmd_t           slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;

  assign full      = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_cmd   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !full) begin
      wr_ptr_nxt = wr_ptr_r + PTR_W'(1);
    end
    if (pop && not_empty) begin
      rd_ptr_nxt = rd_ptr_r + PTR_W'(1);
    end
    if ((push && !full) && !(pop && not_empty)) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (!(push && !full) && (pop && not_empty)) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (push && !full) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== rtl/core/twsu_back.sv =====
// Back end: timer pool memory, add and tick sequencer, result register.
// Pops twsu_pkg::twsu_cmd_t commands from the queue.
module twsu_back #(
  parameter int WHEEL_SLOTS = 8,
  parameter int TIMER_POOL  = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_not_empty,
  input  twsu_pkg::twsu_cmd_t  q_cmd,
  output logic                 q_pop,
  output logic                 out_strobe,
  output logic [1:0]           out_kind,
  output logic [7:0]           out_expired_id,
  output logic                 out_last
);
  import twsu_pkg::*;

  localparam int SLOT_W = $clog2(WHEEL_SLOTS);
  localparam int IDX_W  = (TIMER_POOL > 1) ? $clog2(TIMER_POOL) : 1;
  localparam int CNT_W  = $clog2(TIMER_POOL + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TIMER_POOL - 1);

  typedef struct packed {
    logic [SLOT_W-1:0]     slot;
    logic [TIMEOUT_W-1:0]  rounds;
    logic [ID_W-1:0]       ident;
    logic [IDX_W-1:0]      age;
  } entry_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_ADD_SCAN,
    B_ADD_DONE,
    B_TICK_SCAN,
    B_RUN_ORD,
    B_RUN_ENT,
    B_RUN_DO
  } bstate_t;

  entry_t              ent_mem [TIMER_POOL];
  logic [IDX_W-1:0]    ord_mem [TIMER_POOL];
  entry_t              ent_rd_r;
  logic [IDX_W-1:0]    ord_rd_r;

  bstate_t             state_r, state_nxt;
  twsu_cmd_t           cmd_r, cmd_nxt;
  logic [TIMER_POOL-1:0] valid_r, valid_nxt;
  logic [IDX_W-1:0]    scan_i_r, scan_i_nxt;
  logic                iss_done_r, iss_done_nxt;
  logic                chk_v_r, chk_v_nxt;
  logic [IDX_W-1:0]    chk_idx_r, chk_idx_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                free_found_r, free_found_nxt;
  logic [IDX_W-1:0]    free_idx_r, free_idx_nxt;
  logic [CNT_W-1:0]    exp_cnt_r, exp_cnt_nxt;
  logic [CNT_W-1:0]    exp_done_r, exp_done_nxt;
  logic [IDX_W-1:0]    pos_r, pos_nxt;
  logic [IDX_W-1:0]    next_age_r, next_age_nxt;
  logic [IDX_W-1:0]    cur_idx_r, cur_idx_nxt;
  logic                strobe_r, strobe_nxt;
  kind_t               kind_r, kind_nxt;
  logic [ID_W-1:0]     id_r, id_nxt;
  logic                last_r, last_nxt;

  logic [IDX_W-1:0]    ent_rd_addr;
  logic [IDX_W-1:0]    ord_rd_addr;
  logic                ent_we;
  logic [IDX_W-1:0]    ent_wa;
  entry_t              ent_wd;
  logic                ord_we;
  logic [IDX_W-1:0]    ord_wa;
  logic [IDX_W-1:0]    ord_wd;
  logic                chk_valid;
  logic                match;

  assign out_strobe     = strobe_r;
  assign out_kind       = kind_r;
  assign out_expired_id = id_r;
  assign out_last       = last_r;

  assign chk_valid = valid_r[chk_idx_r];
  assign match     = chk_valid && (ent_rd_r.slot == SLOT_W'(cmd_r.slot));

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    valid_nxt      = valid_r;
    scan_i_nxt     = scan_i_r;
    iss_done_nxt   = iss_done_r;
    chk_v_nxt      = 1'b0;
    chk_idx_nxt    = scan_i_r;
    cnt_nxt        = cnt_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    exp_cnt_nxt    = exp_cnt_r;
    exp_done_nxt   = exp_done_r;
    pos_nxt        = pos_r;
    next_age_nxt   = next_age_r;
    cur_idx_nxt    = cur_idx_r;
    strobe_nxt     = 1'b0;
    kind_nxt       = kind_r;
    id_nxt         = id_r;
    last_nxt       = last_r;
    q_pop          = 1'b0;
    ent_rd_addr    = scan_i_r;
    ord_rd_addr    = pos_r;
    ent_we         = 1'b0;
    ent_wa         = free_idx_r;
    ent_wd         = ent_rd_r;
    ord_we         = 1'b0;
    ord_wa         = ent_rd_r.age;
    ord_wd         = chk_idx_r;

    if (state_r == B_ADD_SCAN || state_r == B_TICK_SCAN) begin
      chk_v_nxt = !iss_done_r;
      if (!iss_done_r) begin
        if (scan_i_r == LAST_IDX) begin
          iss_done_nxt = 1'b1;
        end else begin
          scan_i_nxt = scan_i_r + IDX_W'(1);
        end
      end
    end

    unique case (state_r)
      B_IDLE: begin
        if (q_not_empty) begin
          q_pop          = 1'b1;
          cmd_nxt        = q_cmd;
          scan_i_nxt     = '0;
          iss_done_nxt   = 1'b0;
          cnt_nxt        = '0;
          free_found_nxt = 1'b0;
          exp_cnt_nxt    = '0;
          unique case (q_cmd.op)
            CMD_ZERO: begin
              strobe_nxt = 1'b1;
              kind_nxt   = KIND_ZERO;
              id_nxt     = q_cmd.id;
              last_nxt   = 1'b1;
            end
            CMD_ADD:  state_nxt = B_ADD_SCAN;
            CMD_TICK: state_nxt = B_TICK_SCAN;
            default:  state_nxt = B_IDLE;
          endcase
        end
      end
      B_ADD_SCAN: begin
        if (chk_v_r) begin
          if (match) begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end
          if (!chk_valid && !free_found_r) begin
            free_found_nxt = 1'b1;
            free_idx_nxt   = chk_idx_r;
          end
          if (chk_idx_r == LAST_IDX) begin
            state_nxt = B_ADD_DONE;
          end
        end
      end
      B_ADD_DONE: begin
        strobe_nxt = 1'b1;
        id_nxt     = cmd_r.id;
        last_nxt   = 1'b1;
        if (free_found_r) begin
          ent_we                = 1'b1;
          ent_wa                = free_idx_r;
          ent_wd.slot           = SLOT_W'(cmd_r.slot);
          ent_wd.rounds         = cmd_r.rounds;
          ent_wd.ident          = cmd_r.id;
          ent_wd.age            = IDX_W'(cnt_r);
          valid_nxt[free_idx_r] = 1'b1;
          kind_nxt              = KIND_ADDED;
        end else begin
          kind_nxt = KIND_FULL;
        end
        state_nxt = B_IDLE;
      end
      B_TICK_SCAN: begin
        if (chk_v_r) begin
          if (match) begin
            ord_we  = 1'b1;
            cnt_nxt = cnt_r + CNT_W'(1);
            if (ent_rd_r.rounds == '0) begin
              exp_cnt_nxt = exp_cnt_r + CNT_W'(1);
            end
          end
          if (chk_idx_r == LAST_IDX) begin
            pos_nxt      = '0;
            next_age_nxt = '0;
            exp_done_nxt = '0;
            state_nxt    = (cnt_nxt == '0) ? B_IDLE : B_RUN_ORD;
          end
        end
      end
      B_RUN_ORD: begin
        state_nxt = B_RUN_ENT;
      end
      B_RUN_ENT: begin
        ent_rd_addr = ord_rd_r;
        cur_idx_nxt = ord_rd_r;
        state_nxt   = B_RUN_DO;
      end
      B_RUN_DO: begin
        if (ent_rd_r.rounds != '0) begin
          ent_we        = 1'b1;
          ent_wa        = cur_idx_r;
          ent_wd.rounds = ent_rd_r.rounds - TIMEOUT_W'(1);
          ent_wd.age    = next_age_r;
          next_age_nxt  = next_age_r + IDX_W'(1);
        end else begin
          valid_nxt[cur_idx_r] = 1'b0;
          strobe_nxt           = 1'b1;
          kind_nxt             = KIND_EXPIRED;
          id_nxt               = ent_rd_r.ident;
          last_nxt             = ((exp_done_r + CNT_W'(1)) == exp_cnt_r);
          exp_done_nxt         = exp_done_r + CNT_W'(1);
        end
        if ((CNT_W'(pos_r) + CNT_W'(1)) == cnt_r) begin
          state_nxt = B_IDLE;
        end else begin
          pos_nxt   = pos_r + IDX_W'(1);
          state_nxt = B_RUN_ORD;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[ent_wa] <= ent_wd;
    end
    ent_rd_r <= ent_mem[ent_rd_addr];
    if (ord_we) begin
      ord_mem[ord_wa] <= ord_wd;
    end
    ord_rd_r <= ord_mem[ord_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= B_IDLE;
      valid_r  <= '0;
      chk_v_r  <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      valid_r  <= valid_nxt;
      chk_v_r  <= chk_v_nxt;
      strobe_r <= strobe_nxt;
    end
    cmd_r        <= cmd_nxt;
    scan_i_r     <= scan_i_nxt;
    iss_done_r   <= iss_done_nxt;
    chk_idx_r    <= chk_idx_nxt;
    cnt_r        <= cnt_nxt;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
    exp_cnt_r    <= exp_cnt_nxt;
    exp_done_r   <= exp_done_nxt;
    pos_r        <= pos_nxt;
    next_age_r   <= next_age_nxt;
    cur_idx_r    <= cur_idx_nxt;
    kind_r       <= kind_nxt;
    id_r         <= id_nxt;
    last_r       <= last_nxt;
  end

endmodule

// ===== rtl/core/timing_wheel_scheduler_unit.sv =====
// Timing wheel scheduler top level: front end, command queue, back end.
// Add: the result follows the pool scan, which counts entries in the target slot and finds a free entry.
// Tick: the pool scan orders the slot by age, then each timer in it passes B_RUN_ORD, B_RUN_ENT and B_RUN_DO.
// Front takes a new item only once its last one is pushed, and stalls while the two-entry queue is full.
// Reset clears wheel position and entry valid bits at once; no clearing pass.
// Results are single-cycle strobes; no receiver stall.
module timing_wheel_scheduler_unit #(
  parameter int WHEEL_SLOTS = 8,
  parameter int TIMER_POOL  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_mode,
  input  logic [15:0] in_timeout,
  input  logic [7:0]  in_timer_id,
  output logic        out_strobe,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_expired_id,
  output logic        out_last
);
  import twsu_pkg::*;

  logic       push;
  twsu_cmd_t  push_cmd;
  logic       q_full;
  logic       q_pop;
  logic       q_not_empty;
  twsu_cmd_t  q_cmd;

  twsu_front #(
    .WHEEL_SLOTS (WHEEL_SLOTS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_mode     (in_mode),
    .in_timeout  (in_timeout),
    .in_timer_id (in_timer_id),
    .q_full      (q_full),
    .push        (push),
    .push_cmd    (push_cmd)
  );

  twsu_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_cmd   (q_cmd)
  );

  twsu_back #(
    .WHEEL_SLOTS (WHEEL_SLOTS),
    .TIMER_POOL  (TIMER_POOL)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_not_empty    (q_not_empty),
    .q_cmd          (q_cmd),
    .q_pop          (q_pop),
    .out_strobe     (out_strobe),
    .out_kind       (out_kind),
    .out_expired_id (out_expired_id),
    .out_last       (out_last)
  );

endmodule

// ===== dv/tb_top.sv =====
// Self-checking bench for timing_wheel_scheduler_unit: directed table, then random adds and ticks.
// Tracks wheel and pool to predict results; typed rows give the kind. Depends on rtl/core/twsu_pkg.sv.
module tb_top;
  import twsu_pkg::*;

  localparam int SLOTS      = 8;
  localparam int POOL       = 16;
  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int RAND_ITEMS = 156;
  localparam int DRAIN_WAIT = 120;
  localparam int CYCLE_CAP  = 400000;
  localparam int ROWS       = 24;

  localparam logic MODE_ADD  = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] ident;
    logic       last;
  } wheel_result_t;

  typedef struct {
    logic        mode;
    logic [15:0] timeout;
    logic [7:0]  ident;
    bit          typed;
    kind_t       kind;
  } stim_row_t;

  logic        clk;
  logic        rst_n       = 1'b0;
  logic        start       = 1'b0;
  logic        busy;
  logic        in_mode     = MODE_ADD;
  logic [15:0] in_timeout  = '0;
  logic [7:0]  in_timer_id = '0;
  logic        out_strobe;
  logic [1:0]  out_kind;
  logic [7:0]  out_expired_id;
  logic        out_last;

  bit          row_typed = 1'b0;
  kind_t       row_kind  = KIND_ADDED;

  logic [SLOT_W-1:0] wheel_pos;
  bit                timer_live [POOL];
  logic [SLOT_W-1:0] timer_slot [POOL];
  logic [15:0]       timer_rounds [POOL];
  logic [7:0]        timer_ident [POOL];
  logic [3:0]        timer_age [POOL];

  wheel_result_t due_results [$];
  int            mismatch_count = 0;
  int            burst_left = 0;

  timing_wheel_scheduler_unit #(
    .WHEEL_SLOTS(SLOTS),
    .TIMER_POOL (POOL)
  ) u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_mode       (in_mode),
    .in_timeout    (in_timeout),
    .in_timer_id   (in_timer_id),
    .out_strobe    (out_strobe),
    .out_kind      (out_kind),
    .out_expired_id(out_expired_id),
    .out_last      (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int wheel_step(input logic mode, input logic [15:0] ticks,
                                    input logic [7:0] ident,
                                    output wheel_result_t res [POOL]);
    int                count;
    int                free_idx;
    int                nres;
    int                next_age;
    int                scan [$];
    logic [SLOT_W-1:0] slot;
    if (mode == MODE_ADD) begin
      if (ticks == 16'd0) begin
        res[0] = '{kind: KIND_ZERO, ident: ident, last: 1'b1};
        return 1;
      end
      slot = SLOT_W'((int'(wheel_pos) + int'(ticks)) % SLOTS);
      count = 0;
      free_idx = -1;
      for (int i = 0; i < POOL; i++) begin
        if (timer_live[i]) begin
          if (timer_slot[i] == slot) count++;
        end else if (free_idx < 0) begin
          free_idx = i;
        end
      end
      if (free_idx < 0) begin
        res[0] = '{kind: KIND_FULL, ident: ident, last: 1'b1};
        return 1;
      end
      timer_live[free_idx]   = 1'b1;
      timer_slot[free_idx]   = slot;
      timer_rounds[free_idx] = 16'((ticks - 16'd1) / SLOTS);
      timer_ident[free_idx]  = ident;
      timer_age[free_idx]    = 4'(count);
      res[0] = '{kind: KIND_ADDED, ident: ident, last: 1'b1};
      return 1;
    end
    wheel_pos = SLOT_W'((int'(wheel_pos) + 1) % SLOTS);
    for (int pos = 0; pos < POOL; pos++) begin
      for (int i = 0; i < POOL; i++) begin
        if (timer_live[i] && timer_slot[i] == wheel_pos && timer_age[i] == pos) begin
          scan.push_back(i);
          break;
        end
      end
    end
    nres = 0;
    next_age = 0;
    foreach (scan[k]) begin
      if (timer_rounds[scan[k]] > 0) begin
        timer_rounds[scan[k]] = timer_rounds[scan[k]] - 16'd1;
        timer_age[scan[k]] = 4'(next_age);
        next_age++;
      end else begin
        timer_live[scan[k]] = 1'b0;
        res[nres] = '{kind: KIND_EXPIRED, ident: timer_ident[scan[k]], last: 1'b0};
        nres++;
      end
    end
    if (nres > 0) res[nres-1].last = 1'b1;
    return nres;
  endfunction

  always @(posedge clk) begin
    wheel_result_t res [POOL];
    wheel_result_t head;
    int            nres;
    if (rst_n) begin
      if (start && !busy) begin
        nres = wheel_step(in_mode, in_timeout, in_timer_id, res);
        if (row_typed) begin
          due_results.push_back(wheel_result_t'{kind: row_kind, ident: in_timer_id,
                                                last: 1'b1});
        end else begin
          for (int k = 0; k < nres; k++) due_results.push_back(res[k]);
        end
      end
      if (out_strobe) begin
        if (due_results.size() == 0) begin
          $error("unexpected result: kind %0d id %0d last %0d",
                 out_kind, out_expired_id, out_last);
          mismatch_count++;
        end else begin
          head = due_results.pop_front();
          if (out_kind !== head.kind) begin
            $error("out_kind: expected %0d, actual %0d", head.kind, out_kind);
            mismatch_count++;
          end
          if (out_expired_id !== head.ident) begin
            $error("out_expired_id: expected %0d, actual %0d", head.ident, out_expired_id);
            mismatch_count++;
          end
          if (out_last !== head.last) begin
            $error("out_last: expected %0d, actual %0d", head.last, out_last);
            mismatch_count++;
          end
        end
      end
    end
  end

  initial begin
    repeat (CYCLE_CAP) @(posedge clk);
    $display("FAIL timing_wheel_scheduler_unit");
    $finish;
  end

  task automatic send_item(input logic mode, input logic [15:0] ticks, input logic [7:0] ident,
                           input bit typed, input kind_t kind);
    in_mode     <= mode;
    in_timeout  <= ticks;
    in_timer_id <= ident;
    row_typed   <= typed;
    row_kind    <= kind;
    start       <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic hold_off(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
  endtask

  task automatic pace_sender();
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 6));
    end
    burst_left--;
  endtask

  initial begin
    stim_row_t   rows [ROWS];
    int          pick;
    logic        mode;
    logic [15:0] ticks;

    foreach (timer_live[i]) timer_live[i] = 1'b0;
    wheel_pos = '0;

    rows[0] = '{MODE_ADD, 16'd0, 8'hFF, 1'b1, KIND_ZERO};
    for (int k = 0; k < POOL; k++) rows[1+k] = '{MODE_ADD, 16'd1, 8'(k * 17), 1'b1, KIND_ADDED};
    rows[17] = '{MODE_ADD, 16'd1, 8'hAA, 1'b1, KIND_FULL};
    rows[18] = '{MODE_TICK, 16'hFFFF, 8'hFF, 1'b0, KIND_EXPIRED};
    rows[19] = '{MODE_TICK, 16'h0000, 8'h00, 1'b0, KIND_EXPIRED};
    rows[20] = '{MODE_ADD, 16'hFFFF, 8'h00, 1'b1, KIND_ADDED};
    rows[21] = '{MODE_ADD, 16'd9, 8'h5A, 1'b1, KIND_ADDED};
    rows[22] = '{MODE_ADD, 16'd1, 8'hA5, 1'b1, KIND_ADDED};
    rows[23] = '{MODE_TICK, 16'h5555, 8'h33, 1'b0, KIND_EXPIRED};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[r]) begin
      pace_sender();
      send_item(rows[r].mode, rows[r].timeout, rows[r].ident, rows[r].typed, rows[r].kind);
    end
    drain_results();

    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == RAND_ITEMS / 2) drain_results();
      pace_sender();
      pick = $urandom_range(0, 99);
      mode = (pick < 42) ? MODE_TICK : MODE_ADD;
      if (pick < 42) ticks = 16'($urandom_range(0, 65535));
      else if (pick < 46) ticks = 16'd0;
      else if (pick < 47) ticks = 16'($urandom_range(256, 65535));
      else if (pick < 60) ticks = 16'($urandom_range(17, 64));
      else ticks = 16'($urandom_range(1, 16));
      send_item(mode, ticks, 8'($urandom_range(0, 255)), 1'b0, KIND_ADDED);
    end

    drain_results();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0 && due_results.size() == 0) begin
      $display("PASS timing_wheel_scheduler_unit");
    end else begin
      $display("FAIL timing_wheel_scheduler_unit");
    end
    $finish;
  end

endmodule
